// ===== hdl/sacm_pkg.sv =====
`timescale 1ns / 1ps
package sacm_pkg;

    // widths of the channel payloads
    localparam int SET_W    = 8;
    localparam int TAG_W    = 32;
    localparam int STAMP_W  = 32;
    localparam int COST_W   = 18;
    localparam int CNT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_LRU        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 3'd4;

    // access kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_STORE = 1'b1;

    // cost constants
    localparam logic [COST_W-1:0] MISS_UNIT      = 18'd100;
    localparam logic [12:0]       MAX_BLOCK_BYTES = 13'd4096;

    // one line of the tag store
    typedef struct packed {
        logic               present;
        logic               dirty;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] fill_stamp;
        logic [STAMP_W-1:0] access_stamp;
    } line_t;

    localparam int LINE_W = $bits(line_t);

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic idle;
        logic look;
        logic scan;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic req_valid;
        logic need_scan;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/sacm_ifs.sv =====
`timescale 1ns / 1ps
interface sacm_req_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [sacm_pkg::SET_W-1:0]   set_index;
    logic [sacm_pkg::TAG_W-1:0]   tag;
    logic [sacm_pkg::STAMP_W-1:0] time_stamp;

    modport source (output valid, mode, set_index, tag, time_stamp, input ready);
    modport sink (input valid, mode, set_index, tag, time_stamp, output ready);
endinterface

interface sacm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic                        evicted_dirty;
    logic [sacm_pkg::COST_W-1:0] cycles_added;
    logic [sacm_pkg::CNT_W-1:0]  load_count;
    logic [sacm_pkg::CNT_W-1:0]  store_count;
    logic [sacm_pkg::CNT_W-1:0]  load_hits;
    logic [sacm_pkg::CNT_W-1:0]  store_hits;
    logic [sacm_pkg::CNT_W-1:0]  total_cycles;

    modport source (output valid, hit, evicted_dirty, cycles_added, load_count,
                    store_count, load_hits, store_hits, total_cycles, input ready);
    modport sink (input valid, hit, evicted_dirty, cycles_added, load_count,
                  store_count, load_hits, store_hits, total_cycles, output ready);
endinterface

interface sacm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sacm_pkg::CFG_IDX_W-1:0]  index;
    logic [sacm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/sacm_ram.sv =====
`timescale 1ns / 1ps
module sacm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/sacm_ctrl.sv =====
`timescale 1ns / 1ps
module sacm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  sacm_pkg::status_t status,
    output sacm_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOK   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (status.clear_done) state_next = S_IDLE;
            S_IDLE:   if (status.req_valid) state_next = S_LOOK;
            S_LOOK:   state_next = status.need_scan ? S_SCAN : S_COMMIT;
            S_SCAN:   if (status.scan_last) state_next = S_COMMIT;
            S_COMMIT: if (status.out_free) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands
    always_comb
    begin
        cmd.clear  = (state_reg == S_CLEAR);
        cmd.idle   = (state_reg == S_IDLE);
        cmd.look   = (state_reg == S_LOOK);
        cmd.scan   = (state_reg == S_SCAN);
        cmd.commit = (state_reg == S_COMMIT) && status.out_free;
    end

endmodule

// ===== hdl/sacm_dp.sv =====
`timescale 1ns / 1ps
module sacm_dp #(
    parameter int SETS = 256,
    parameter int WAYS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sacm_pkg::cmd_t    cmd,
    output sacm_pkg::status_t status,
    sacm_req_if.sink          req,
    sacm_rsp_if.source        rsp,
    sacm_cfg_if.sink          cfg
);

    localparam int IW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WIW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW  = $clog2(WAYS + 1);
    localparam int ROW_W = WAYS * sacm_pkg::LINE_W;

    typedef sacm_pkg::line_t [WAYS-1:0] row_t;

    // configuration registers
    logic        write_back_reg;
    logic        write_allocate_reg;
    logic        use_lru_reg;
    logic [12:0] block_bytes_reg;
    logic [3:0]  ways_in_use_reg;

    // transaction registers
    logic                         mode_reg;
    logic [IW-1:0]                set_reg;
    logic [sacm_pkg::TAG_W-1:0]   tag_reg;
    logic [sacm_pkg::STAMP_W-1:0] ts_reg;
    row_t                         row_reg;
    logic                         hit_reg;
    logic [WIW-1:0]               hit_way_reg;
    logic                         empty_reg;
    logic [WIW-1:0]               empty_way_reg;
    logic [WIW-1:0]               cnt_reg;
    logic [sacm_pkg::STAMP_W-1:0] best_reg;
    logic [WIW-1:0]               best_way_reg;
    logic [IW-1:0]                clr_reg;

    // counters and result
    logic [sacm_pkg::CNT_W-1:0]  loads_reg;
    logic [sacm_pkg::CNT_W-1:0]  stores_reg;
    logic [sacm_pkg::CNT_W-1:0]  load_hits_reg;
    logic [sacm_pkg::CNT_W-1:0]  store_hits_reg;
    logic [sacm_pkg::CNT_W-1:0]  total_reg;
    logic                        out_valid_reg;
    logic                        out_hit_reg;
    logic                        out_dirty_reg;
    logic [sacm_pkg::COST_W-1:0] out_cost_reg;

    logic [IW-1:0]    set_tab [256];
    logic [ROW_W-1:0] rd_data;
    row_t             rd_row;
    row_t             new_row;
    logic             accept;
    logic [NW-1:0]    n_ways;
    logic             look_hit;
    logic [WIW-1:0]   look_hit_way;
    logic             look_empty;
    logic [WIW-1:0]   look_empty_way;
    logic             fill_needed;
    logic [sacm_pkg::STAMP_W-1:0] scan_stamp;
    logic [16:0]      block_cost;
    logic [12:0]      bb_clamped;
    logic [WIW-1:0]   fill_way;
    logic             evict_dirty;
    logic [sacm_pkg::COST_W-1:0] cost;

    // set index folded into the set range
    for (genvar i = 0; i < 256; i++)
    begin : g_set_tab
        assign set_tab[i] = IW'(i % SETS);
    end

    assign accept    = cmd.idle && req.valid;
    assign req.ready = cmd.idle;
    assign cfg.ready = 1'b1;
    assign rd_row    = row_t'(rd_data);

    sacm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.clear || cmd.commit),
        .waddr (cmd.clear ? clr_reg : set_reg),
        .wdata (cmd.clear ? '0 : ROW_W'(new_row)),
        .re    (accept),
        .raddr (set_tab[req.set_index]),
        .rdata (rd_data)
    );

    // effective way count for fills
    always_comb
    begin
        if (ways_in_use_reg == 4'd0)
        begin
            n_ways = NW'(1);
        end
        else if (int'(ways_in_use_reg) > WAYS)
        begin
            n_ways = NW'(WAYS);
        end
        else
        begin
            n_ways = NW'(ways_in_use_reg);
        end
    end

    // parallel tag compare and empty-way search on the row just read
    always_comb
    begin
        look_hit       = 1'b0;
        look_hit_way   = '0;
        look_empty     = 1'b0;
        look_empty_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (rd_row[w].present && rd_row[w].tag == tag_reg)
            begin
                look_hit     = 1'b1;
                look_hit_way = WIW'(w);
            end
            if (w < int'(n_ways) && !rd_row[w].present)
            begin
                look_empty     = 1'b1;
                look_empty_way = WIW'(w);
            end
        end
    end

    assign fill_needed = (mode_reg == sacm_pkg::MODE_LOAD) || write_allocate_reg;

    // victim stamp of the way under scan
    assign scan_stamp = use_lru_reg ? row_reg[cnt_reg].access_stamp
                                    : row_reg[cnt_reg].fill_stamp;

    // fill cost from block size
    assign bb_clamped = (block_bytes_reg > sacm_pkg::MAX_BLOCK_BYTES)
                        ? sacm_pkg::MAX_BLOCK_BYTES : block_bytes_reg;
    assign block_cost = 17'(bb_clamped[12:2]) * 17'd100;

    // updated row and cost
    always_comb
    begin
        new_row     = row_reg;
        fill_way    = empty_reg ? empty_way_reg : best_way_reg;
        evict_dirty = 1'b0;
        cost        = '0;
        if (hit_reg)
        begin
            new_row[hit_way_reg].access_stamp = ts_reg;
            if (mode_reg == sacm_pkg::MODE_STORE)
            begin
                new_row[hit_way_reg].dirty = write_back_reg;
                cost = write_back_reg ? sacm_pkg::COST_W'(1) : sacm_pkg::MISS_UNIT;
            end
            else
            begin
                cost = sacm_pkg::COST_W'(1);
            end
        end
        else
        begin
            if (fill_needed)
            begin
                evict_dirty = !empty_reg && row_reg[fill_way].dirty;
                new_row[fill_way].present      = 1'b1;
                new_row[fill_way].dirty        = 1'b0;
                new_row[fill_way].tag          = tag_reg;
                new_row[fill_way].fill_stamp   = ts_reg;
                new_row[fill_way].access_stamp = ts_reg;
                cost = sacm_pkg::COST_W'(block_cost);
                if (evict_dirty)
                begin
                    cost = cost + sacm_pkg::COST_W'(block_cost);
                end
            end
            if (mode_reg == sacm_pkg::MODE_STORE && !write_back_reg)
            begin
                cost = cost + sacm_pkg::MISS_UNIT;
            end
        end
    end

    // status to the controller
    always_comb
    begin
        status.clear_done = (clr_reg == IW'(SETS - 1));
        status.req_valid  = req.valid;
        status.need_scan  = !look_hit && fill_needed && !look_empty;
        status.scan_last  = (int'(cnt_reg) == int'(n_ways) - 1);
        status.out_free   = !out_valid_reg || rsp.ready;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_back_reg     <= 1'b1;
            write_allocate_reg <= 1'b1;
            use_lru_reg        <= 1'b1;
            block_bytes_reg    <= 13'd16;
            ways_in_use_reg    <= 4'd8;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sacm_pkg::CFG_WRITE_BACK:     write_back_reg     <= cfg.data[0];
                sacm_pkg::CFG_WRITE_ALLOCATE: write_allocate_reg <= cfg.data[0];
                sacm_pkg::CFG_USE_LRU:        use_lru_reg        <= cfg.data[0];
                sacm_pkg::CFG_BLOCK_BYTES:    block_bytes_reg    <= cfg.data;
                sacm_pkg::CFG_WAYS_IN_USE:    ways_in_use_reg    <= cfg.data[3:0];
                default:                      ;
            endcase
        end
    end

    // transaction payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            set_reg  <= set_tab[req.set_index];
            tag_reg  <= req.tag;
            ts_reg   <= req.time_stamp;
        end
        if (cmd.look)
        begin
            row_reg       <= rd_row;
            hit_reg       <= look_hit;
            hit_way_reg   <= look_hit_way;
            empty_reg     <= look_empty;
            empty_way_reg <= look_empty_way;
            cnt_reg       <= '0;
        end
        if (cmd.scan)
        begin
            if (cnt_reg == '0 || scan_stamp < best_reg)
            begin
                best_reg     <= scan_stamp;
                best_way_reg <= cnt_reg;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.commit)
        begin
            out_hit_reg   <= hit_reg;
            out_dirty_reg <= evict_dirty;
            out_cost_reg  <= cost;
        end
    end

    // clearing pass, counters and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg        <= '0;
            loads_reg      <= '0;
            stores_reg     <= '0;
            load_hits_reg  <= '0;
            store_hits_reg <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_reg + sacm_pkg::CNT_W'(cost);
                if (mode_reg == sacm_pkg::MODE_STORE)
                begin
                    stores_reg <= stores_reg + 1'b1;
                    if (hit_reg) store_hits_reg <= store_hits_reg + 1'b1;
                end
                else
                begin
                    loads_reg <= loads_reg + 1'b1;
                    if (hit_reg) load_hits_reg <= load_hits_reg + 1'b1;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.evicted_dirty = out_dirty_reg;
    assign rsp.cycles_added  = out_cost_reg;
    assign rsp.load_count    = loads_reg;
    assign rsp.store_count   = stores_reg;
    assign rsp.load_hits     = load_hits_reg;
    assign rsp.store_hits    = store_hits_reg;
    assign rsp.total_cycles  = total_reg;

endmodule

// ===== hdl/set_assoc_cache_model.sv =====
`timescale 1ns / 1ps
// Set-associative cache tag store with timing and hit counters. Each set is one
// row of a memory with one write and one read port, holding all its ways. An
// access that hits, finds an empty way or needs no fill is accepted and read,
// tag-compared in parallel and written back with the result; when a victim must
// be chosen, the ways in use are scanned before the write back, the smallest
// stamp being found one way per cycle. The response sits in an output register,
// so a new access is taken while it waits. After reset a clearing pass walks the
// memory before an access is taken; configuration writes are taken at any time.
module set_assoc_cache_model #(
    parameter int SETS = 256,
    parameter int WAYS = 8
) (
    input logic       clk,
    input logic       rst_n,
    sacm_req_if.sink  req,
    sacm_rsp_if.source rsp,
    sacm_cfg_if.sink  cfg
);

    sacm_pkg::cmd_t    cmd;
    sacm_pkg::status_t status;

    sacm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sacm_dp #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .req    (req),
        .rsp    (rsp),
        .cfg    (cfg)
    );

    // a hit never reports a dirty eviction
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.evicted_dirty))
        else $error("hit reported with eviction");

    // hit costs are fixed
    a_hit_cost: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.hit |-> (rsp.cycles_added == 18'd1 || rsp.cycles_added == 18'd100))
        else $error("bad hit cost");

    // no access is taken while the block works on one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("second access taken during work");

    // no load hits are counted while the load count is zero
    a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.load_count == 32'd0 |-> rsp.load_hits == 32'd0)
        else $error("load hits without loads");

endmodule
